// ===== design/ssnc_pkg.sv =====
// Shared constants, types and the segment decode function for the
// seven-segment number and clock formatter. No dependencies.
package ssnc_pkg;

    localparam int unsigned WORK_W     = 14;  // magnitudes up to 9999
    localparam int unsigned QUOT_W     = 10;  // quotients up to 999
    localparam int unsigned REM_W      = 4;
    localparam int unsigned RECIP_W    = 16;
    localparam int unsigned RECIP_SH   = 19;
    localparam logic [RECIP_W-1:0] RECIP_TEN = 16'd52429;  // ceil(2^19 / 10)

    localparam logic [15:0] BLINK_RESET = 16'd1000;

    localparam logic [7:0] SEG_BLANK = 8'h00;
    localparam logic [7:0] SEG_MINUS = 8'h40;
    localparam logic [7:0] SEG_COLON = 8'h80;

    typedef struct packed {
        logic [QUOT_W-1:0] quot;
        logic [REM_W-1:0]  rem;
    } ssnc_div_t;

    function automatic logic [7:0] seg_of(input logic [REM_W-1:0] digit);
        logic [7:0] seg;
        unique case (digit)
            4'd0:    seg = 8'h3f;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5b;
            4'd3:    seg = 8'h4f;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6d;
            4'd6:    seg = 8'h7d;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7f;
            4'd9:    seg = 8'h6f;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

// ===== design/ssnc_div10.sv =====
// Divide-by-ten unit shared by every digit step: reciprocal multiply,
// then remainder by shift-and-add correction. Depends on ssnc_pkg.
module ssnc_div10
    import ssnc_pkg::*;
(
    input  logic [WORK_W-1:0] dividend,
    output ssnc_div_t         result
);

    logic [WORK_W+RECIP_W-1:0] product;
    logic [QUOT_W-1:0]         quot;
    logic [WORK_W-1:0]         times_ten;
    logic [WORK_W-1:0]         diff;

    assign product   = {{RECIP_W{1'b0}}, dividend} * {{WORK_W{1'b0}}, RECIP_TEN};
    assign quot      = product[RECIP_SH +: QUOT_W];
    assign times_ten = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
    assign diff      = dividend - times_ten;

    assign result.quot = quot;
    assign result.rem  = diff[REM_W-1:0];

endmodule

// ===== design/ssnc_colon.sv =====
// Colon blink state: interval register, last toggle time stamp and the
// wrap-around elapsed-time compare. Depends on ssnc_pkg.
module ssnc_colon
    import ssnc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [15:0] cfg_write_data,
    input  logic        update,
    input  logic [31:0] now_ms,
    output logic        colon_on
);

    logic [15:0] interval_reg, interval_next;
    logic [31:0] last_reg, last_next;
    logic        colon_reg, colon_next;
    logic [31:0] elapsed;

    assign elapsed = now_ms - last_reg;

    always_comb
    begin
        interval_next = cfg_write_en ? cfg_write_data : interval_reg;
        last_next     = last_reg;
        colon_next    = colon_reg;
        if (update && (elapsed > {16'd0, interval_reg}))
        begin
            last_next  = now_ms;
            colon_next = ~colon_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= BLINK_RESET;
            last_reg     <= 32'd0;
            colon_reg    <= 1'b0;
        end
        else
        begin
            interval_reg <= interval_next;
            last_reg     <= last_next;
            colon_reg    <= colon_next;
        end
    end

    assign colon_on = colon_reg;

endmodule

// ===== design/seven_segment_number_clock_formatter.sv =====
// Top level of the four-digit seven-segment formatter: digit sequencer,
// result register and handshakes. Depends on ssnc_pkg, ssnc_div10, ssnc_colon.
//
// Usage:
//   The input channel (in_valid / in_stall) carries one request per
//   transaction: a signed integer to show (action 0) or hours and minutes
//   (action 1). A transaction completes at a clock edge where in_valid is
//   high and in_stall is low. Requests out of range are taken and dropped
//   with no result.
//   The output channel (out_valid / out_stall) carries four segment bytes,
//   leftmost digit in segments_left. A result stays on the port until the
//   receiver takes it with out_stall low.
//   The blink interval is written through cfg_write_en / cfg_write_data
//   while the block is idle.
// Timing:
//   Each request runs four digit steps through one shared divide-by-ten
//   unit, rightmost digit first. When the output register is free, the
//   result is loaded into it at the last step, and a new request is taken
//   only after that. in_stall is high during the steps.
//   If the receiver stalls, the finished result waits inside and the next
//   request is held off until the output register frees up.
// Reset:
//   rst_n clears the sequencer, the output valid, the colon (off), the
//   last toggle time stamp (zero), and sets the interval to 1000 ms.
module seven_segment_number_clock_formatter
    import ssnc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic [15:0]       cfg_write_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              action,
    input  logic signed [15:0] number_value,
    input  logic              fill_zeros,
    input  logic [7:0]        hours_value,
    input  logic [7:0]        minutes_value,
    input  logic [31:0]       now_ms,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        segments_left,
    output logic [7:0]        segments_second,
    output logic [7:0]        segments_third,
    output logic [7:0]        segments_right
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    localparam logic [1:0] STEP_FIRST = 2'd0;
    localparam logic [1:0] STEP_HOURS = 2'd2;
    localparam logic [1:0] STEP_LAST  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [1:0]        step_reg, step_next;
    logic [WORK_W-1:0] work_reg, work_next;
    logic [6:0]        hours_reg, hours_next;
    logic              clock_reg, clock_next;
    logic              neg_reg, neg_next;
    logic              fill_reg, fill_next;
    logic [7:0]        bytes_reg [0:3];
    logic [7:0]        bytes_next [0:3];
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        left_reg, left_next;
    logic [7:0]        second_reg, second_next;
    logic [7:0]        third_reg, third_next;
    logic [7:0]        right_reg, right_next;

    logic              accept;
    logic              in_range;
    logic              start;
    logic              out_free;
    logic              load;
    logic [15:0]       magnitude;
    logic [WORK_W-1:0] div_in;
    ssnc_div_t         div_out;
    logic              show;
    logic [7:0]        cur_byte;
    logic              colon_on;

    // Input is only taken between requests; the sequencer owns the unit.
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (action)
            in_range = (hours_value <= 8'd99) && (minutes_value <= 8'd99);
        else
            in_range = (number_value <= 16'sd9999) && (number_value >= -16'sd999);
    end

    assign start     = accept && in_range;
    assign magnitude = number_value[15] ? (16'd0 - number_value) : number_value;

    // The colon decision is made as the clock request is taken.
    ssnc_colon u_colon (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .update         (start && action),
        .now_ms         (now_ms),
        .colon_on       (colon_on)
    );

    // Clock requests switch from minutes to hours halfway through.
    assign div_in = (clock_reg && (step_reg == STEP_HOURS)) ? {7'd0, hours_reg} : work_reg;

    ssnc_div10 u_div10 (
        .dividend (div_in),
        .result   (div_out)
    );

    // A digit shows if anything remains at or left of it, if it is the
    // units digit, or if zero fill is on (always on for the clock).
    always_comb
    begin
        show     = (div_in != '0) || (step_reg == STEP_FIRST) || fill_reg;
        cur_byte = show ? seg_of(div_out.rem) : SEG_BLANK;
        if (clock_reg && (step_reg == STEP_HOURS) && colon_on)
            cur_byte = cur_byte | SEG_COLON;
        if (neg_reg && (step_reg == STEP_LAST))
            cur_byte = SEG_MINUS;
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        work_next  = work_reg;
        hours_next = hours_reg;
        clock_next = clock_reg;
        neg_next   = neg_reg;
        fill_next  = fill_reg;
        for (int i = 0; i < 4; i++)
            bytes_next[i] = bytes_reg[i];
        load = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                    step_next  = STEP_FIRST;
                    clock_next = action;
                    hours_next = hours_value[6:0];
                    if (action)
                    begin
                        work_next = {7'd0, minutes_value[6:0]};
                        neg_next  = 1'b0;
                        fill_next = 1'b1;
                    end
                    else
                    begin
                        work_next = magnitude[WORK_W-1:0];
                        neg_next  = number_value[15];
                        fill_next = fill_zeros;
                    end
                end
            end
            ST_RUN:
            begin
                bytes_next[step_reg] = cur_byte;
                work_next = {{(WORK_W-QUOT_W){1'b0}}, div_out.quot};
                step_next = step_reg + 2'd1;
                if (step_reg == STEP_LAST)
                begin
                    if (out_free)
                    begin
                        load       = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register; the leftmost byte comes straight from the last step
    // when the result is loaded in that same cycle.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        left_next      = left_reg;
        second_next    = second_reg;
        third_next     = third_reg;
        right_next     = right_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b1;
            left_next      = (state_reg == ST_RUN) ? cur_byte : bytes_reg[3];
            second_next    = bytes_reg[2];
            third_next     = bytes_reg[1];
            right_next     = bytes_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg   <= work_next;
        hours_reg  <= hours_next;
        clock_reg  <= clock_next;
        neg_reg    <= neg_next;
        fill_reg   <= fill_next;
        for (int i = 0; i < 4; i++)
            bytes_reg[i] <= bytes_next[i];
        left_reg   <= left_next;
        second_reg <= second_next;
        third_reg  <= third_next;
        right_reg  <= right_next;
    end

    assign out_valid       = out_valid_reg;
    assign segments_left   = left_reg;
    assign segments_second = second_reg;
    assign segments_third  = third_reg;
    assign segments_right  = right_reg;

endmodule
